// ===== hdl/sbcfp_pkg.sv =====
// Shared types and constants for the sprite blitter.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package sbcfp_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int MAX_SPRITE_DIM  = 1024;
   localparam int MAX_SCREEN_DIM  = 512;

   localparam int IDX_W   = 8;                          // color index
   localparam int RGB_W   = 24;
   localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
   localparam int DIM_W   = $clog2(MAX_SPRITE_DIM);     // sprite width/height
   localparam int SCR_W   = $clog2(MAX_SCREEN_DIM);     // clip coordinates
   localparam int SH_W    = SCR_W + 1;                  // screen_height
   localparam int ADDR_W  = 2 * SCR_W;                  // framebuffer address
   localparam int PROD_W  = SCR_W + SH_W;
   localparam int POS_W   = 16;
   localparam int ORG_W   = POS_W + 2;                  // anchored corner
   localparam int CRD_W   = ORG_W + 1;                  // pixel coordinate math

   localparam logic [IDX_W-1:0] RECOLOR_LO = 8'h70;
   localparam logic [IDX_W-1:0] RECOLOR_HI = 8'h7F;
   localparam int               PAL_SCALE_SHIFT = 2;   // times four

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   // register indexes of the configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LEFT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_RIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_TOP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_BOTTOM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd6;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      KIND_PALETTE = 2'd0,
      KIND_BEGIN   = 2'd1,
      KIND_PIXEL   = 2'd2
   } kind_type;

   typedef enum logic {
      OP_PAL_WRITE = 1'b0,
      OP_PIX_WRITE = 1'b1
   } op_type;

   typedef struct packed {
      logic [SCR_W-1:0]        clip_left;
      logic [SCR_W-1:0]        clip_right;
      logic [SCR_W-1:0]        clip_top;
      logic [SCR_W-1:0]        clip_bottom;
      logic signed [POS_W-1:0] offset_x;
      logic signed [POS_W-1:0] offset_y;
      logic [SH_W-1:0]         screen_height;
   } cfg_type;

   // one queued job for the back end
   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  idx;     // palette entry or final pixel index
      logic [RGB_W-1:0]  rgb;     // scaled color (palette write only)
      logic [SCR_W-1:0]  col;     // screen column (pixel write only)
      logic [SH_W-1:0]   row;     // mirrored row (pixel write only)
   } qentry_type;

endpackage

// ===== hdl/sbcfp_front.sv =====
// Front end: accepts items, keeps sprite state and pixel counters, clips.
// Depends on sbcfp_pkg; feeds sbcfp_queue.
`timescale 1ns / 1ps

module sbcfp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  sbcfp_pkg::cfg_type                cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic signed [sbcfp_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [sbcfp_pkg::POS_W-1:0] req_pos_y,
   input  logic [sbcfp_pkg::DIM_W-1:0]       req_width,
   input  logic [sbcfp_pkg::DIM_W-1:0]       req_height,
   input  logic signed [sbcfp_pkg::POS_W-1:0] req_anchor_x,
   input  logic signed [sbcfp_pkg::POS_W-1:0] req_anchor_y,
   input  logic [1:0]                        req_flip,
   input  logic [sbcfp_pkg::IDX_W-1:0]       req_recolor_base,
   input  logic [sbcfp_pkg::IDX_W-1:0]       req_color_index,
   input  logic [sbcfp_pkg::RGB_W-1:0]       req_palette_rgb,
   input  logic                              q_full,
   output logic                              q_push,
   output sbcfp_pkg::qentry_type             q_data
);
   import sbcfp_pkg::*;

   logic signed [ORG_W-1:0] origin_x_ff, origin_x_in;
   logic signed [ORG_W-1:0] origin_y_ff, origin_y_in;
   logic [DIM_W-1:0]        width_ff, width_in;
   logic [DIM_W-1:0]        height_ff, height_in;
   logic [1:0]              flip_ff, flip_in;
   logic [IDX_W-1:0]        recolor_ff, recolor_in;
   logic [DIM_W-1:0]        col_ff, col_in;
   logic [DIM_W-1:0]        row_ff, row_in;
   logic                    vis_ff, vis_in;

   logic                    accept;
   kind_type                kind;
   logic signed [CRD_W-1:0] xs, ys, xa, ya, xw, yh, w_s, h_s;
   logic signed [CRD_W-1:0] left_s, right_s, top_s, bottom_s, sh_s;
   logic                    begin_vis;
   logic [DIM_W:0]          col_next, row_next;
   logic [DIM_W-1:0]        rx, ry;
   logic signed [CRD_W-1:0] px, py;
   logic                    clip_in;
   logic [IDX_W-1:0]        t_final;
   logic                    recolor_hit;
   logic [SH_W-1:0]         mirror_row;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign kind      = kind_type'(req_kind);

   assign left_s   = $signed({{(CRD_W-SCR_W){1'b0}}, cfg.clip_left});
   assign right_s  = $signed({{(CRD_W-SCR_W){1'b0}}, cfg.clip_right});
   assign top_s    = $signed({{(CRD_W-SCR_W){1'b0}}, cfg.clip_top});
   assign bottom_s = $signed({{(CRD_W-SCR_W){1'b0}}, cfg.clip_bottom});
   assign sh_s     = $signed({{(CRD_W-SH_W){1'b0}}, cfg.screen_height});

   // sprite begin: anchored top-left corner and whole-sprite window test
   always_comb begin
      w_s = $signed({{(CRD_W-DIM_W){1'b0}}, req_width});
      h_s = $signed({{(CRD_W-DIM_W){1'b0}}, req_height});
      xs  = CRD_W'(req_pos_x) + CRD_W'(cfg.offset_x);
      ys  = CRD_W'(req_pos_y) + CRD_W'(cfg.offset_y);
      xa  = req_flip[0] ? (xs - w_s + CRD_W'(req_anchor_x)) : (xs - CRD_W'(req_anchor_x));
      ya  = req_flip[1] ? (ys - h_s + CRD_W'(req_anchor_y)) : (ys - CRD_W'(req_anchor_y));
      xw  = xa + w_s;
      yh  = ya + h_s;
      begin_vis = (req_width != '0) && (req_height != '0) &&
                  (xw >= left_s) && (xa <= right_s) &&
                  (yh >= top_s) && (ya <= bottom_s);
   end

   // pixel: mirrored position, recolor, per-pixel clip
   always_comb begin
      col_next = {1'b0, col_ff} + 1'b1;
      row_next = {1'b0, row_ff} + 1'b1;
      rx = flip_ff[0] ? (width_ff - DIM_W'(1) - col_ff) : col_ff;
      ry = flip_ff[1] ? (height_ff - DIM_W'(1) - row_ff) : row_ff;
      px = CRD_W'(origin_x_ff) + $signed({{(CRD_W-DIM_W){1'b0}}, rx});
      py = CRD_W'(origin_y_ff) + $signed({{(CRD_W-DIM_W){1'b0}}, ry});
      clip_in = (px >= left_s) && (px <= right_s) &&
                (py >= top_s) && (py <= bottom_s) && (py < sh_s);
      recolor_hit = (recolor_ff != '0) && (req_color_index >= RECOLOR_LO) &&
                    (req_color_index <= RECOLOR_HI);
      t_final = recolor_hit ? (recolor_ff + (req_color_index - RECOLOR_LO))
                            : req_color_index;
      mirror_row = cfg.screen_height - SH_W'(1) - py[SH_W-1:0];
   end

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      flip_in     = flip_ff;
      recolor_in  = recolor_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      vis_in      = vis_ff;
      q_push      = 1'b0;
      q_data.op   = OP_PIX_WRITE;
      q_data.idx  = t_final;
      q_data.rgb  = {req_palette_rgb[23:16] << PAL_SCALE_SHIFT,
                     req_palette_rgb[15:8]  << PAL_SCALE_SHIFT,
                     req_palette_rgb[7:0]   << PAL_SCALE_SHIFT};
      q_data.col  = px[SCR_W-1:0];
      q_data.row  = mirror_row;
      if (accept) begin
         case (kind)
            KIND_PALETTE: begin
               q_push     = 1'b1;
               q_data.op  = OP_PAL_WRITE;
               q_data.idx = req_color_index;
            end
            KIND_BEGIN: begin
               origin_x_in = xa[ORG_W-1:0];
               origin_y_in = ya[ORG_W-1:0];
               width_in    = req_width;
               height_in   = req_height;
               flip_in     = req_flip;
               recolor_in  = req_recolor_base;
               col_in      = '0;
               row_in      = '0;
               vis_in      = begin_vis;
            end
            KIND_PIXEL: begin
               if (vis_ff) begin
                  if (col_next >= {1'b0, width_ff}) begin
                     col_in = '0;
                     row_in = row_next[DIM_W-1:0];
                     if (row_next >= {1'b0, height_ff}) begin
                        vis_in = 1'b0;
                     end
                  end else begin
                     col_in = col_next[DIM_W-1:0];
                  end
                  q_push = (req_color_index != '0) && clip_in;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         flip_ff     <= '0;
         recolor_ff  <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         vis_ff      <= 1'b0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         flip_ff     <= flip_in;
         recolor_ff  <= recolor_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         vis_ff      <= vis_in;
      end
   end

endmodule

// ===== hdl/sbcfp_queue.sv =====
// Short job queue between front and back end.
// Depends on sbcfp_pkg (entry type and depth).
`timescale 1ns / 1ps

module sbcfp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sbcfp_pkg::qentry_type push_data,
   input  logic                  pop,
   output sbcfp_pkg::qentry_type head_data,
   output logic                  empty,
   output logic                  full
);
   import sbcfp_pkg::*;

   qentry_type        slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

// ===== hdl/sbcfp_back.sv =====
// Back end: palette memory, address multiply and the result register.
// Depends on sbcfp_pkg; drains sbcfp_queue.
`timescale 1ns / 1ps

module sbcfp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sbcfp_pkg::SH_W-1:0]    screen_height,
   input  sbcfp_pkg::qentry_type         head_data,
   input  logic                          q_empty,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sbcfp_pkg::ADDR_W-1:0]  rsp_pixel_address,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue,
   output logic [sbcfp_pkg::IDX_W-1:0]   rsp_written_index
);
   import sbcfp_pkg::*;

   logic [RGB_W-1:0]  pal_mem [PALETTE_ENTRIES];

   logic              s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0] s1_prod_ff;
   logic [SH_W-1:0]   s1_row_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [RGB_W-1:0]  s1_rgb_ff;

   logic              out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [RGB_W-1:0]  out_rgb_ff;
   logic [IDX_W-1:0]  out_idx_ff;

   logic              out_load, s1_free, s1_load;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] addr_sum;

   assign out_load = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign s1_free  = !s1_valid_ff || out_load;
   assign q_pop    = !q_empty && s1_free;
   assign s1_load  = q_pop && (head_data.op == OP_PIX_WRITE);
   assign prod     = PROD_W'(head_data.col) * PROD_W'(screen_height);
   assign addr_sum = s1_prod_ff + PROD_W'(s1_row_ff);

   always_comb begin
      s1_valid_in  = s1_free ? s1_load : s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // palette write port and registered read port
   always_ff @(posedge clock) begin
      if (q_pop && (head_data.op == OP_PAL_WRITE)) begin
         pal_mem[head_data.idx[PAL_AW-1:0]] <= head_data.rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_rgb_ff <= pal_mem[head_data.idx[PAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_prod_ff <= prod;
         s1_row_ff  <= head_data.row;
         s1_idx_ff  <= head_data.idx;
      end
      if (out_load) begin
         out_addr_ff <= addr_sum[ADDR_W-1:0];
         out_rgb_ff  <= s1_rgb_ff;
         out_idx_ff  <= s1_idx_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_address = out_addr_ff;
   assign rsp_red           = out_rgb_ff[23:16];
   assign rsp_green         = out_rgb_ff[15:8];
   assign rsp_blue          = out_rgb_ff[7:0];
   assign rsp_written_index = out_idx_ff;

   a_s1_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_free) |=> s1_valid_ff)
      else $error("stage one dropped a stalled pixel");

   a_load_needs_s1: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !out_load)
      else $error("result register overwritten while stalled");

   a_pal_no_stage: assert property (@(posedge clock) disable iff (reset)
      (q_pop && head_data.op == OP_PAL_WRITE) |=> !s1_valid_ff || $past(s1_valid_ff && !s1_free))
      else $error("palette write entered the pixel stage");

endmodule

// ===== hdl/sprite_blitter_clip_flip_palette_unit.sv =====
// Sprite blitter top level: config registers, front end, job queue, back end.
// Depends on sbcfp_pkg, sbcfp_front, sbcfp_queue, sbcfp_back.
// Path: an accepted pixel beat is written into the queue, then registered in stage one
//   (palette read plus column multiply), then in the result register (address add).
// Throughput: one beat per cycle of any kind, one pop per cycle, both while not stalled.
// Reset: synchronous, active high; clears sprite state, queue and config, not the palette.
`timescale 1ns / 1ps

module sprite_blitter_clip_flip_palette_unit (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write port
   input  logic                                csr_we,
   input  logic [sbcfp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sbcfp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic signed [sbcfp_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [sbcfp_pkg::POS_W-1:0]  req_pos_y,
   input  logic [sbcfp_pkg::DIM_W-1:0]         req_width,
   input  logic [sbcfp_pkg::DIM_W-1:0]         req_height,
   input  logic signed [sbcfp_pkg::POS_W-1:0]  req_anchor_x,
   input  logic signed [sbcfp_pkg::POS_W-1:0]  req_anchor_y,
   input  logic [1:0]                          req_flip,
   input  logic [sbcfp_pkg::IDX_W-1:0]         req_recolor_base,
   input  logic [sbcfp_pkg::IDX_W-1:0]         req_color_index,
   input  logic [sbcfp_pkg::RGB_W-1:0]         req_palette_rgb,
   // response channel: one framebuffer write per visible pixel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sbcfp_pkg::ADDR_W-1:0]        rsp_pixel_address,
   output logic [7:0]                          rsp_red,
   output logic [7:0]                          rsp_green,
   output logic [7:0]                          rsp_blue,
   output logic [sbcfp_pkg::IDX_W-1:0]         rsp_written_index
);
   import sbcfp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       q_push, q_pop, q_empty, q_full;
   qentry_type q_in_data, q_head;

   // Config registers. Writes must land only while the block is idle; the user
   // must ensure it, as the block does not; front and back ends read them unshadowed.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CLIP_LEFT:     cfg_in.clip_left     = csr_wdata[SCR_W-1:0];
            CSR_CLIP_RIGHT:    cfg_in.clip_right    = csr_wdata[SCR_W-1:0];
            CSR_CLIP_TOP:      cfg_in.clip_top      = csr_wdata[SCR_W-1:0];
            CSR_CLIP_BOTTOM:   cfg_in.clip_bottom   = csr_wdata[SCR_W-1:0];
            CSR_OFFSET_X:      cfg_in.offset_x      = $signed(csr_wdata[POS_W-1:0]);
            CSR_OFFSET_Y:      cfg_in.offset_y      = $signed(csr_wdata[POS_W-1:0]);
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[SH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_left     <= SCR_W'(0);
         cfg_ff.clip_right    <= SCR_W'(399);
         cfg_ff.clip_top      <= SCR_W'(0);
         cfg_ff.clip_bottom   <= SCR_W'(239);
         cfg_ff.offset_x      <= '0;
         cfg_ff.offset_y      <= '0;
         cfg_ff.screen_height <= SH_W'(240);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: sprite setup, row-major pixel walk, flip, recolor, clip.
   // Emits palette writes and surviving pixel writes as queue jobs.
   sbcfp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_width        (req_width),
      .req_height       (req_height),
      .req_anchor_x     (req_anchor_x),
      .req_anchor_y     (req_anchor_y),
      .req_flip         (req_flip),
      .req_recolor_base (req_recolor_base),
      .req_color_index  (req_color_index),
      .req_palette_rgb  (req_palette_rgb),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_in_data)
   );

   // Jobs stay in order, so a palette write always lands before any
   // later pixel reads that entry.
   sbcfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head_data (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Back end: palette lookup, rotated address (column times stride plus
   // mirrored row), result register that holds under rsp_ready stalls.
   sbcfp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .screen_height     (cfg_ff.screen_height),
      .head_data         (q_head),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_written_index (rsp_written_index)
   );

endmodule

// ===== sim/fb_write_board_pkg.sv =====
// Scoreboard for the sprite blitter bench: a bit-exact predictor of the
// framebuffer writes and the queue of writes still owed. Depends on sbcfp_pkg.
`timescale 1ns / 1ps

package fb_write_board_pkg;
   import sbcfp_pkg::*;

   typedef struct {
      logic [1:0]              kind;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [DIM_W-1:0]        width;
      logic [DIM_W-1:0]        height;
      logic signed [POS_W-1:0] anchor_x;
      logic signed [POS_W-1:0] anchor_y;
      logic [1:0]              flip;
      logic [IDX_W-1:0]        recolor_base;
      logic [IDX_W-1:0]        color_index;
      logic [RGB_W-1:0]        palette_rgb;
   } blit_req_type;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [IDX_W-1:0]  index;
   } fb_write_type;

   class fb_write_board;
      cfg_type                 cfg;
      logic [RGB_W-1:0]        pal [PALETTE_ENTRIES];
      logic signed [ORG_W-1:0] org_x, org_y;
      logic [DIM_W-1:0]        spr_w, spr_h, col_cnt, row_cnt;
      logic [1:0]              spr_flip;
      logic [IDX_W-1:0]        spr_recolor;
      bit                      spr_live;
      fb_write_type            owed [$];
      int                      errors;

      function new();
         cfg.clip_left     = '0;
         cfg.clip_right    = SCR_W'(399);
         cfg.clip_top      = '0;
         cfg.clip_bottom   = SCR_W'(239);
         cfg.offset_x      = '0;
         cfg.offset_y      = '0;
         cfg.screen_height = SH_W'(240);
         foreach (pal[i]) pal[i] = '0;
         org_x = '0;
         org_y = '0;
         spr_w = '0;
         spr_h = '0;
         col_cnt = '0;
         row_cnt = '0;
         spr_flip = '0;
         spr_recolor = '0;
         spr_live = 1'b0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_CLIP_LEFT:     cfg.clip_left     = v[SCR_W-1:0];
            CSR_CLIP_RIGHT:    cfg.clip_right    = v[SCR_W-1:0];
            CSR_CLIP_TOP:      cfg.clip_top      = v[SCR_W-1:0];
            CSR_CLIP_BOTTOM:   cfg.clip_bottom   = v[SCR_W-1:0];
            CSR_OFFSET_X:      cfg.offset_x      = v;
            CSR_OFFSET_Y:      cfg.offset_y      = v;
            CSR_SCREEN_HEIGHT: cfg.screen_height = v[SH_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // one accepted request beat; queues the framebuffer write it causes
      function void note_beat(blit_req_type b);
         int x, y, w, h, lx, ly, px, py, sh;
         logic [IDX_W-1:0] t;
         fb_write_type wr;
         case (b.kind)
            KIND_PALETTE:
               // each raw byte times four, mod 256
               pal[b.color_index] = {b.palette_rgb[21:16], 2'b00,
                                     b.palette_rgb[13:8], 2'b00,
                                     b.palette_rgb[5:0], 2'b00};
            KIND_BEGIN: begin
               w = int'(b.width);
               h = int'(b.height);
               x = int'(b.pos_x) + int'($signed(cfg.offset_x));
               y = int'(b.pos_y) + int'($signed(cfg.offset_y));
               x = b.flip[0] ? x - w + int'(b.anchor_x) : x - int'(b.anchor_x);
               y = b.flip[1] ? y - h + int'(b.anchor_y) : y - int'(b.anchor_y);
               org_x = ORG_W'(x);
               org_y = ORG_W'(y);
               spr_w = b.width;
               spr_h = b.height;
               spr_flip = b.flip;
               spr_recolor = b.recolor_base;
               col_cnt = '0;
               row_cnt = '0;
               spr_live = w != 0 && h != 0 &&
                          x + w >= int'(cfg.clip_left) && x <= int'(cfg.clip_right) &&
                          y + h >= int'(cfg.clip_top) && y <= int'(cfg.clip_bottom);
            end
            KIND_PIXEL:
               if (spr_live) begin
                  lx = int'(col_cnt);
                  ly = int'(row_cnt);
                  if (lx + 1 >= int'(spr_w)) begin
                     col_cnt = '0;
                     row_cnt = row_cnt + 1'b1;
                     if (ly + 1 >= int'(spr_h)) spr_live = 1'b0;
                  end else begin
                     col_cnt = col_cnt + 1'b1;
                  end
                  t = b.color_index;
                  if (t != '0) begin
                     px = int'(org_x) + (spr_flip[0] ? int'(spr_w) - lx - 1 : lx);
                     py = int'(org_y) + (spr_flip[1] ? int'(spr_h) - ly - 1 : ly);
                     if (spr_recolor != '0 && t >= RECOLOR_LO && t <= RECOLOR_HI)
                        t = t - RECOLOR_LO + spr_recolor;
                     sh = int'(cfg.screen_height);
                     if (px >= int'(cfg.clip_left) && px <= int'(cfg.clip_right) &&
                         py >= int'(cfg.clip_top) && py <= int'(cfg.clip_bottom) &&
                         py < sh) begin
                        wr.addr = ADDR_W'(px * sh + sh - 1 - py);
                        {wr.red, wr.green, wr.blue} = pal[t];
                        wr.index = t;
                        owed.push_back(wr);
                     end
                  end
               end
            default: ;
         endcase
      endfunction

      task flag(string what);
         errors++;
         $display("MISMATCH @%0t: %s", $time, what);
      endtask

      task check_beat(fb_write_type got);
         fb_write_type want;
         if (owed.size() == 0) begin
            flag($sformatf("write with none owed: addr %0h index %0h", got.addr, got.index));
            return;
         end
         want = owed.pop_front();
         if (got.addr !== want.addr)
            flag($sformatf("addr %0h, wanted %0h", got.addr, want.addr));
         if (got.red !== want.red)
            flag($sformatf("red %0h, wanted %0h", got.red, want.red));
         if (got.green !== want.green)
            flag($sformatf("green %0h, wanted %0h", got.green, want.green));
         if (got.blue !== want.blue)
            flag($sformatf("blue %0h, wanted %0h", got.blue, want.blue));
         if (got.index !== want.index)
            flag($sformatf("index %0h, wanted %0h", got.index, want.index));
      endtask
   endclass

endpackage

// ===== sim/tb_sprite_blitter_clip_flip_palette_unit.sv =====
// Bench top for the sprite blitter: drives palette, sprite and pixel beats,
// checks every framebuffer write. Depends on sbcfp_pkg and fb_write_board_pkg.
`timescale 1ns / 1ps

module tb_sprite_blitter_clip_flip_palette_unit;
   import sbcfp_pkg::*;
   import fb_write_board_pkg::*;

   localparam int         LIMIT_CYCLES = 400000;
   localparam int         SETTLE       = 8;    // pipe plus queue slack
   localparam int         HOLD_CYCLES  = 120;  // long back-pressure stretch
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ORDER [7] = '{
      CSR_CLIP_LEFT, CSR_CLIP_RIGHT, CSR_CLIP_TOP, CSR_CLIP_BOTTOM,
      CSR_OFFSET_X, CSR_OFFSET_Y, CSR_SCREEN_HEIGHT};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   logic                    req_valid        = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_kind         = '0;
   logic signed [POS_W-1:0] req_pos_x        = '0;
   logic signed [POS_W-1:0] req_pos_y        = '0;
   logic [DIM_W-1:0]        req_width        = '0;
   logic [DIM_W-1:0]        req_height       = '0;
   logic signed [POS_W-1:0] req_anchor_x     = '0;
   logic signed [POS_W-1:0] req_anchor_y     = '0;
   logic [1:0]              req_flip         = '0;
   logic [IDX_W-1:0]        req_recolor_base = '0;
   logic [IDX_W-1:0]        req_color_index  = '0;
   logic [RGB_W-1:0]        req_palette_rgb  = '0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [ADDR_W-1:0]       rsp_pixel_address;
   logic [7:0]              rsp_red, rsp_green, rsp_blue;
   logic [IDX_W-1:0]        rsp_written_index;

   fb_write_board board = new();

   bit pacing     = 1'b0;   // random gaps and stalls on or off, both sides
   int hold_asks  = 0;      // bumped by the stimulus to ask for a long stall
   int items_sent = 0;
   int cycles     = 0;

   sprite_blitter_clip_flip_palette_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_width         (req_width),
      .req_height        (req_height),
      .req_anchor_x      (req_anchor_x),
      .req_anchor_y      (req_anchor_y),
      .req_flip          (req_flip),
      .req_recolor_base  (req_recolor_base),
      .req_color_index   (req_color_index),
      .req_palette_rgb   (req_palette_rgb),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_written_index (rsp_written_index)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake or a lost write ends here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (!pacing) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 55) return 0;
      if (r < 92) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   // every field random; callers override what the beat kind needs
   function automatic blit_req_type rand_item(logic [1:0] kind);
      blit_req_type b;
      b.kind         = kind;
      b.pos_x        = POS_W'($urandom);
      b.pos_y        = POS_W'($urandom);
      b.width        = DIM_W'($urandom);
      b.height       = DIM_W'($urandom);
      b.anchor_x     = POS_W'($urandom);
      b.anchor_y     = POS_W'($urandom);
      b.flip         = 2'($urandom);
      b.recolor_base = IDX_W'($urandom);
      b.color_index  = IDX_W'($urandom);
      b.palette_rgb  = RGB_W'($urandom);
      return b;
   endfunction

   function automatic blit_req_type sprite_hdr(int px, int py, int w, int h,
                                               int ax, int ay, int fl, int rc);
      blit_req_type b;
      b = rand_item(KIND_BEGIN);
      b.pos_x        = POS_W'(px);
      b.pos_y        = POS_W'(py);
      b.width        = DIM_W'(w);
      b.height       = DIM_W'(h);
      b.anchor_x     = POS_W'(ax);
      b.anchor_y     = POS_W'(ay);
      b.flip         = 2'(fl);
      b.recolor_base = IDX_W'(rc);
      return b;
   endfunction

   function automatic blit_req_type pixel_item(logic [IDX_W-1:0] c);
      blit_req_type b;
      b = rand_item(KIND_PIXEL);
      b.color_index = c;
      return b;
   endfunction

   function automatic blit_req_type palette_item(logic [IDX_W-1:0] idx,
                                                 logic [RGB_W-1:0] rgb);
      blit_req_type b;
      b = rand_item(KIND_PALETTE);
      b.color_index = idx;
      b.palette_rgb = rgb;
      return b;
   endfunction

   // transparent, inside the recolor range, or anything else
   function automatic logic [IDX_W-1:0] pick_color();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 15) return '0;
      if (r < 40) return RECOLOR_LO + IDX_W'($urandom_range(0, 15));
      return IDX_W'($urandom_range(1, 255));
   endfunction

   // Offer one beat and hold it until taken. Entered and left just after a
   // rising edge; valid only drops when a gap follows.
   task automatic send(input blit_req_type b);
      int gap;
      req_valid        <= 1'b1;
      req_kind         <= b.kind;
      req_pos_x        <= b.pos_x;
      req_pos_y        <= b.pos_y;
      req_width        <= b.width;
      req_height       <= b.height;
      req_anchor_x     <= b.anchor_x;
      req_anchor_y     <= b.anchor_y;
      req_flip         <= b.flip;
      req_recolor_base <= b.recolor_base;
      req_color_index  <= b.color_index;
      req_palette_rgb  <= b.palette_rgb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_beat(b);
      if (b.kind != KIND_UNUSED) items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering, let every owed write land, then let the pipe go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write all registers in index order; unused upper bits get junk
   task automatic load_regs(input logic [CSR_DATA_W-1:0] vals [7]);
      logic [CSR_DATA_W-1:0] data;
      for (int i = 0; i < 7; i++) begin
         case (CSR_ORDER[i])
            CSR_OFFSET_X, CSR_OFFSET_Y: data = vals[i];
            CSR_SCREEN_HEIGHT: data = {6'($urandom), vals[i][SH_W-1:0]};
            default:           data = {7'($urandom), vals[i][SCR_W-1:0]};
         endcase
         csr_we    <= 1'b1;
         csr_index <= CSR_ORDER[i];
         csr_wdata <= data;
         @(posedge clock);
         board.set_reg(CSR_ORDER[i], data);
      end
      csr_we <= 1'b0;
   endtask

   // choose position and hotspot so the anchored corner lands at c
   task automatic aim(input int c, input int off, input int w, input bit mirror,
                      output logic signed [POS_W-1:0] pos,
                      output logic signed [POS_W-1:0] anc);
      int p;
      p = c - off + int'($urandom_range(0, 32)) - 16;
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      pos = POS_W'(p);
      anc = POS_W'(mirror ? c - p - off + w : p + off - c);
   endtask

   // A sprite near the clip window: header, then its pixels in order. A cut
   // sprite stops early; a whole one sometimes gets a stray pixel after.
   task automatic sprite_run(input int lo, input int hi, input bit cut);
      blit_req_type b;
      int w, h, span, cx, cy, n;
      b = rand_item(KIND_BEGIN);
      w = int'($urandom_range(lo, hi));
      h = int'($urandom_range(lo, hi));
      b.width  = DIM_W'(w);
      b.height = DIM_W'(h);
      b.recolor_base = ($urandom_range(0, 9) < 4) ? '0 : IDX_W'($urandom_range(1, 255));
      span = int'(board.cfg.clip_right) - int'(board.cfg.clip_left);
      if (span < 0) span = 0;
      cx = int'(board.cfg.clip_left) - w - 2 + int'($urandom_range(0, span + w + 4));
      span = int'(board.cfg.clip_bottom) - int'(board.cfg.clip_top);
      if (span < 0) span = 0;
      cy = int'(board.cfg.clip_top) - h - 2 + int'($urandom_range(0, span + h + 4));
      aim(cx, int'($signed(board.cfg.offset_x)), w, b.flip[0], b.pos_x, b.anchor_x);
      aim(cy, int'($signed(board.cfg.offset_y)), h, b.flip[1], b.pos_y, b.anchor_y);
      send(b);
      n = w * h;
      if (cut) n = int'($urandom_range(0, n - 1));
      else if ($urandom_range(0, 9) == 0) n++;
      for (int i = 0; i < n; i++) send(pixel_item(pick_color()));
   endtask

   task automatic random_phase(input int n, input bit idle);
      int stop_at, r;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         pacing = idle && ($urandom_range(0, 4) != 0);
         r = int'($urandom_range(0, 99));
         if (r < 68) sprite_run(1, (r < 6) ? 12 : 5, 1'b0);
         else if (r < 76) sprite_run(1, 5, 1'b1);
         else if (r < 84) send(rand_item(KIND_PALETTE));
         else if (r < 97) send(rand_item(2'($urandom)));   // noise of any kind
         else drain();
      end
   endtask

   // Write sink: checks each accepted beat, then picks next cycle's ready.
   // A hold request parks ready low while a hold counter loaded from HOLD_CYCLES runs down.
   initial begin : fb_sink
      int stall, hold, asks_seen;
      fb_write_type got;
      stall = 0;
      hold = 0;
      asks_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.addr  = rsp_pixel_address;
            got.red   = rsp_red;
            got.green = rsp_green;
            got.blue  = rsp_blue;
            got.index = rsp_written_index;
            board.check_beat(got);
         end
         if (hold_asks != asks_seen) begin
            asks_seen = hold_asks;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] regs [7];
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole palette first so no pixel ever reads an unwritten entry
      pacing = 1'b1;
      for (int i = 0; i < PALETTE_ENTRIES; i++)
         send(palette_item(IDX_W'(i), RGB_W'($urandom)));

      // --- directed beats, reset window 0..399 x 0..239, height 240 ---
      // sprite at the origin with recolor on: transparent pixel, both ends of
      // the recolor range, top index, neighbors just outside the range
      send(sprite_hdr(0, 0, 3, 2, 0, 0, 0, 8'h90));
      send(pixel_item(8'h00));
      send(pixel_item(RECOLOR_LO));
      send(pixel_item(RECOLOR_HI));
      send(pixel_item(8'hFF));
      send(pixel_item(8'h01));
      send(pixel_item(8'h6F));
      send(pixel_item(8'h42));                      // past the last pixel
      // both mirrors, hotspot inside, bottom edge, recolor wrapping past 255
      send(sprite_hdr(10, 239, 2, 2, 1, 1, 3, 8'hF8));
      send(pixel_item(RECOLOR_HI));
      send(pixel_item(8'h75));
      send(pixel_item(8'h80));
      send(pixel_item(RECOLOR_LO));
      // mirrored across the left edge, recolor off: one column clipped
      send(sprite_hdr(0, 5, 2, 1, 1, 0, 1, 0));
      send(pixel_item(8'h75));
      send(pixel_item(8'h33));
      // right of the window: whole sprite rejected
      send(sprite_hdr(400, 0, 4, 4, 0, 0, 0, 0));
      send(pixel_item(8'h11));
      // zero width: no sprite
      send(sprite_hdr(5, 5, 0, 3, 0, 0, 0, 0));
      send(pixel_item(8'h11));
      send(rand_item(KIND_UNUSED));
      // field extremes, lands far off screen
      send(sprite_hdr(32767, -32768, 1023, 1023, -32768, 32767, 2, 255));
      // extreme palette write, then the bottom-right corner pixel
      send(palette_item(8'hFF, 24'hFFFFFF));
      send(sprite_hdr(399, 239, 1, 1, 0, 0, 0, 0));
      send(pixel_item(8'hFF));
      drain();

      // reset settings, no idling at all
      random_phase(20, 1'b0);
      drain();

      // full window, largest screen; start with a long sink stall so the
      // queue fills and the input stalls
      load_regs('{16'd0, 16'd511, 16'd0, 16'd511, 16'd0, 16'd0, 16'd512});
      hold_asks <= hold_asks + 1;
      pacing = 1'b0;
      sprite_run(6, 6, 1'b0);
      random_phase(25, 1'b1);
      drain();

      // narrow window, extreme offsets, clip rows below the screen height
      load_regs('{16'd100, 16'd200, 16'd50, 16'd60, 16'h8000, 16'h7FFF, 16'd55});
      random_phase(25, 1'b1);
      drain();

      // oversized screen height: addresses wrap
      load_regs('{16'd300, 16'd511, 16'd0, 16'd511, 16'($urandom), 16'($urandom), 16'd1023});
      random_phase(25, 1'b1);
      drain();

      // random settings, sometimes an inverted window
      regs[0] = 16'($urandom_range(0, 511));
      regs[1] = 16'($urandom_range(0, 511));
      regs[2] = 16'($urandom_range(0, 511));
      regs[3] = 16'($urandom_range(0, 511));
      regs[4] = 16'(int'($urandom_range(0, 600)) - 300);
      regs[5] = 16'(int'($urandom_range(0, 600)) - 300);
      regs[6] = 16'($urandom_range(1, 512));
      load_regs(regs);
      random_phase(25, 1'b1);

      pacing = 1'b0;
      drain();
      if (board.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
